// ===== rtl/core/bmpfb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmpfb_pkg
// Shared types and constants for the 32-bit BMP to framebuffer writer.
// ----------------------------------------------------------------------------
package bmpfb_pkg;

  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 480;

  // signed width of screen positions: 32-bit image sizes plus sign and carry
  localparam int POS_W = 34;

  localparam logic [7:0]  SIG_LO     = 8'h42;
  localparam logic [7:0]  SIG_HI     = 8'h4D;
  localparam logic [31:0] OFS_START  = 32'h0000_000A;
  localparam logic [31:0] OFS_WIDTH  = 32'h0000_0012;
  localparam logic [31:0] OFS_HEIGHT = 32'h0000_0016;
  localparam logic [31:0] HEADER_END = 32'h0000_001A;

  localparam logic [1:0] STATUS_PIXEL   = 2'd0;
  localparam logic [1:0] STATUS_NOT_BMP = 2'd1;
  localparam logic [1:0] STATUS_SHORT   = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X     = 2'd0,
    REG_ORIGIN_Y     = 2'd1,
    REG_CENTER_IMAGE = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  pixel_x;
    logic [8:0]  pixel_y;
    logic [11:0] color;
    logic        write_enable;
    logic        final_pixel;
  } out_item_t;

  typedef struct packed {
    logic [9:0] origin_x;
    logic [8:0] origin_y;
    logic       center_image;
  } cfg_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_push_t;

endpackage
`default_nettype wire

// ===== rtl/core/bmpfb_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmpfb_decode
// Header capture, pixel assembly, placement and clipping, one byte a cycle while byte_fire is high.
// ----------------------------------------------------------------------------
module bmpfb_decode (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                byte_fire,
  input  wire bmpfb_pkg::in_item_t byte_item,
  input  wire bmpfb_pkg::cfg_t     cfg,
  output bmpfb_pkg::res_push_t     push
);

  localparam int PW = bmpfb_pkg::POS_W;

  logic [31:0]   byte_offset_r, byte_offset_nxt;
  logic [31:0]   data_start_r, data_start_nxt;
  logic [31:0]   width_r, width_nxt;
  logic [31:0]   height_r, height_nxt;
  logic [31:0]   col_r, col_nxt;
  logic [31:0]   row_r, row_nxt;
  logic [31:0]   ydown_r, ydown_nxt;
  logic          top_down_r, top_down_nxt;
  logic          stopped_r, stopped_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [7:0]    blue_r, blue_nxt;
  logic [7:0]    green_r, green_nxt;

  logic [31:0]   wm1_r;
  logic [PW-1:0] cen_ox_r, cen_oy_r;
  logic [PW-1:0] cen_dx, cen_dy;

  logic [PW-1:0] ox, oy, pos_x, pos_y;
  logic [31:0]   img_y;
  logic          on_screen, last_pix, row_end;

  logic [7:0]    b;
  logic          eof;
  logic [31:0]   off;
  logic          in_pix;

  assign b   = byte_item.file_byte;
  assign eof = byte_item.end_of_file;
  assign off = byte_offset_r;

  // centering offsets and width-1 follow the header registers
  assign cen_dx = PW'(bmpfb_pkg::SCREEN_WIDTH) - {{(PW-32){1'b0}}, width_r};
  assign cen_dy = PW'(bmpfb_pkg::SCREEN_HEIGHT) - {{(PW-32){1'b0}}, height_r};

  always_ff @(posedge clk) begin
    wm1_r    <= width_r - 32'd1;
    cen_ox_r <= {cen_dx[PW-1], cen_dx[PW-1:1]};
    cen_oy_r <= {cen_dy[PW-1], cen_dy[PW-1:1]};
  end

  // placement and clipping
  assign ox    = cfg.center_image ? cen_ox_r : {{(PW-10){1'b0}}, cfg.origin_x};
  assign oy    = cfg.center_image ? cen_oy_r : {{(PW-9){1'b0}}, cfg.origin_y};
  assign img_y = top_down_r ? row_r : ydown_r;
  assign pos_x = ox + {{(PW-32){1'b0}}, col_r};
  assign pos_y = oy + {{(PW-32){1'b0}}, img_y};

  assign on_screen = !pos_x[PW-1] && (pos_x[PW-2:0] < (PW-1)'(bmpfb_pkg::SCREEN_WIDTH)) &&
                     !pos_y[PW-1] && (pos_y[PW-2:0] < (PW-1)'(bmpfb_pkg::SCREEN_HEIGHT));
  assign row_end   = (col_r == wm1_r);
  assign last_pix  = row_end && (ydown_r == 32'd0);

  assign in_pix = (off >= bmpfb_pkg::HEADER_END) && (off >= data_start_r);

  always_comb begin
    byte_offset_nxt = byte_offset_r;
    data_start_nxt  = data_start_r;
    width_nxt       = width_r;
    height_nxt      = height_r;
    col_nxt         = col_r;
    row_nxt         = row_r;
    ydown_nxt       = ydown_r;
    top_down_nxt    = top_down_r;
    stopped_nxt     = stopped_r;
    phase_nxt       = phase_r;
    blue_nxt        = blue_r;
    green_nxt       = green_r;
    push            = '0;

    if (byte_fire) begin
      if (!stopped_r) begin
        if ((off == 32'd0 && b != bmpfb_pkg::SIG_LO) ||
            (off == 32'd1 && b != bmpfb_pkg::SIG_HI)) begin
          push.valid       = 1'b1;
          push.item.status = bmpfb_pkg::STATUS_NOT_BMP;
          stopped_nxt      = 1'b1;
        end else begin
          for (int k = 0; k < 4; k++) begin
            if (off == bmpfb_pkg::OFS_START + 32'(k)) begin
              data_start_nxt[8*k +: 8] = b;
            end
            if (off == bmpfb_pkg::OFS_WIDTH + 32'(k)) begin
              width_nxt[8*k +: 8] = b;
            end
            if (off == bmpfb_pkg::OFS_HEIGHT + 32'(k)) begin
              height_nxt[8*k +: 8] = b;
            end
          end
          // sign of the height selects row order
          if (off == bmpfb_pkg::OFS_HEIGHT + 32'd3) begin
            if (height_nxt[31]) begin
              top_down_nxt = 1'b1;
              ydown_nxt    = ~height_nxt;
              height_nxt   = 32'd0 - height_nxt;
            end else begin
              ydown_nxt = height_nxt - 32'd1;
            end
          end
          if (in_pix) begin
            if (width_r == 32'd0 || height_r == 32'd0) begin
              stopped_nxt = 1'b1;
            end else begin
              case (phase_r)
                2'd0: blue_nxt  = b;
                2'd1: green_nxt = b;
                2'd2: begin
                  push.valid             = 1'b1;
                  push.item.status       = bmpfb_pkg::STATUS_PIXEL;
                  push.item.pixel_x      = on_screen ? pos_x[9:0] : 10'd0;
                  push.item.pixel_y      = on_screen ? pos_y[8:0] : 9'd0;
                  push.item.color        = {blue_r[7:4], green_r[7:4], b[7:4]};
                  push.item.write_enable = on_screen;
                  push.item.final_pixel  = last_pix;
                  if (row_end) begin
                    col_nxt   = 32'd0;
                    row_nxt   = row_r + 32'd1;
                    ydown_nxt = ydown_r - 32'd1;
                  end else begin
                    col_nxt = col_r + 32'd1;
                  end
                  if (last_pix) begin
                    stopped_nxt = 1'b1;
                  end
                end
                default: ;
              endcase
              phase_nxt = phase_r + 2'd1;
            end
          end
        end
        if (off != '1) begin
          byte_offset_nxt = off + 32'd1;
        end
        if (eof && !stopped_nxt) begin
          push             = '0;
          push.valid       = 1'b1;
          push.item.status = bmpfb_pkg::STATUS_SHORT;
        end
      end
      if (eof) begin
        byte_offset_nxt = '0;
        data_start_nxt  = '0;
        width_nxt       = '0;
        height_nxt      = '0;
        col_nxt         = '0;
        row_nxt         = '0;
        ydown_nxt       = '0;
        top_down_nxt    = 1'b0;
        stopped_nxt     = 1'b0;
        phase_nxt       = '0;
        blue_nxt        = '0;
        green_nxt       = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_offset_r <= '0;
      data_start_r  <= '0;
      width_r       <= '0;
      height_r      <= '0;
      col_r         <= '0;
      row_r         <= '0;
      ydown_r       <= '0;
      top_down_r    <= 1'b0;
      stopped_r     <= 1'b0;
      phase_r       <= '0;
      blue_r        <= '0;
      green_r       <= '0;
    end else begin
      byte_offset_r <= byte_offset_nxt;
      data_start_r  <= data_start_nxt;
      width_r       <= width_nxt;
      height_r      <= height_nxt;
      col_r         <= col_nxt;
      row_r         <= row_nxt;
      ydown_r       <= ydown_nxt;
      top_down_r    <= top_down_nxt;
      stopped_r     <= stopped_nxt;
      phase_r       <= phase_nxt;
      blue_r        <= blue_nxt;
      green_r       <= green_nxt;
    end
  end

  a_no_result_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r && !(byte_fire && eof) |-> !push.valid)
    else $error("result produced after decode stopped");

  a_write_only_for_pixels: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid && push.item.write_enable |-> push.item.status == bmpfb_pkg::STATUS_PIXEL)
    else $error("write enable on a status result");

  a_column_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !stopped_r && width_r != 32'd0 && col_r != 32'd0 |-> col_r < width_r)
    else $error("column counter beyond image width");

endmodule
`default_nettype wire

// ===== rtl/core/bmpfb_outq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmpfb_outq
// Result register with a skid stage so bytes keep flowing during a stall until the skid fills.
// ----------------------------------------------------------------------------
module bmpfb_outq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire bmpfb_pkg::res_push_t push,
  output logic                      can_accept,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output bmpfb_pkg::out_item_t      out_item
);

  logic                 main_valid_r, main_valid_nxt;
  logic                 skid_valid_r, skid_valid_nxt;
  bmpfb_pkg::out_item_t main_r, main_nxt;
  bmpfb_pkg::out_item_t skid_r, skid_nxt;
  logic                 pop;

  assign pop        = main_valid_r && out_ready;
  assign can_accept = !skid_valid_r;
  assign out_valid  = main_valid_r;
  assign out_item   = main_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push.valid) begin
      if (!main_valid_r || pop) begin
        main_nxt       = push.item;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push.item;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid holds a result while the output register is empty");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> !skid_valid_r)
    else $error("result pushed into a full queue");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && pop |=> !skid_valid_r && main_valid_r)
    else $error("skid did not move into the output register");

endmodule
`default_nettype wire

// ===== rtl/core/bmp32_to_framebuffer_writer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmp32_to_framebuffer_writer_core
// Streams a 32-bit BMP file a byte at a time and emits placed, clipped
// 12-bit pixels for a framebuffer.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    in_item  (file byte, end of file)
//   out_     output     out_valid / out_ready  out_item (status, x, y, color, flags)
//   cfg_     input      cfg_write_en           cfg_index, cfg_data
//
// one byte per cycle while in_ready is high; a result is formed combinationally
// from its byte and the header and counter registers and held in the output queue
// a two-entry output queue lets bytes keep arriving while a result waits;
// in_ready drops only when both entries are full
// synchronous active-low reset clears the decoder, queue and registers
// ----------------------------------------------------------------------------
module bmp32_to_framebuffer_writer_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire bmpfb_pkg::in_item_t                 in_item,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output bmpfb_pkg::out_item_t                     out_item,
  input  wire logic                                cfg_write_en,
  input  wire logic [bmpfb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bmpfb_pkg::CFG_DATA_W-1:0]    cfg_data
);

  bmpfb_pkg::cfg_t      cfg_r, cfg_nxt;
  bmpfb_pkg::res_push_t push;
  logic                 byte_fire;

  assign byte_fire = in_valid && in_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_write_en) begin
      unique case (bmpfb_pkg::cfg_reg_t'(cfg_index))
        bmpfb_pkg::REG_ORIGIN_X:     cfg_nxt.origin_x     = cfg_data[9:0];
        bmpfb_pkg::REG_ORIGIN_Y:     cfg_nxt.origin_y     = cfg_data[8:0];
        bmpfb_pkg::REG_CENTER_IMAGE: cfg_nxt.center_image = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bmpfb_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_fire (byte_fire),
    .byte_item (in_item),
    .cfg       (cfg_r),
    .push      (push)
  );

  bmpfb_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .can_accept (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule
`default_nettype wire
